/* design/fbpa_pkg.sv */
// Shared constants, codes and types of the fixed block pool allocator.
package fbpa_pkg;

   localparam int POOL_SLOTS      = 8;
   localparam int BLOCKS_PER_POOL = 256;
   localparam int ADDR_BITS       = 32;
   localparam int SLOT_BITS       = $clog2(POOL_SLOTS);
   localparam int IDX_BITS        = $clog2(BLOCKS_PER_POOL);
   localparam int CNT_BITS        = 9;
   localparam int SIZE_BITS       = 17;
   localparam int PROD_BITS       = SIZE_BITS + CNT_BITS;
   localparam int LIMIT_BITS      = 4;
   localparam int LINK_DEPTH      = POOL_SLOTS * BLOCKS_PER_POOL;
   localparam int DIV_STEPS       = ADDR_BITS;
   localparam int STEP_BITS       = $clog2(DIV_STEPS);

   localparam logic [2:0] FUNC_CREATE  = 3'd0;
   localparam logic [2:0] FUNC_ALLOC   = 3'd1;
   localparam logic [2:0] FUNC_RELEASE = 3'd2;
   localparam logic [2:0] FUNC_DELETE  = 3'd3;
   localparam logic [2:0] FUNC_QUERY   = 3'd4;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_FAIL       = 2'd1;
   localparam logic [1:0] STATUS_MISALIGNED = 2'd2;

   localparam logic [CNT_BITS-1:0] LINK_NONE = CNT_BITS'(BLOCKS_PER_POOL);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CHECK,
      S_DIV,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic latch;
      logic mul;
      logic link_rd;
      logic div_start;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic alloc_link;
      logic release_ok;
      logic rel_hit;
      logic div_last;
   } stat_type;

endpackage

/* design/fbpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/fbpa_datapath.sv */
// Datapath: pool slot table, link memory, shared multiplier, divider and result register.
module fbpa_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [fbpa_pkg::LIMIT_BITS-1:0]    csr_pools_in_use_limit,
   input  logic [2:0]                         req_func,
   input  logic [2:0]                         req_pool_index,
   input  logic [15:0]                        req_requested_block_bytes,
   input  logic [8:0]                         req_requested_block_count,
   input  logic [31:0]                        req_region_base,
   input  logic [31:0]                        req_returned_block_address,
   input  fbpa_pkg::cmd_type                  cmd,
   output fbpa_pkg::stat_type                 stat,
   output logic [1:0]                         rsp_status,
   output logic [2:0]                         rsp_assigned_pool,
   output logic [31:0]                        rsp_granted_block_address,
   output logic [16:0]                        rsp_pool_block_bytes,
   output logic [8:0]                         rsp_pool_total_blocks,
   output logic [8:0]                         rsp_pool_free_blocks
);

   localparam int SB = fbpa_pkg::SLOT_BITS;
   localparam int IB = fbpa_pkg::IDX_BITS;
   localparam int CB = fbpa_pkg::CNT_BITS;
   localparam int ZB = fbpa_pkg::SIZE_BITS;
   localparam int AB = fbpa_pkg::ADDR_BITS;
   localparam int PB = fbpa_pkg::PROD_BITS;
   localparam int LB = fbpa_pkg::LIMIT_BITS;
   localparam int NS = fbpa_pkg::POOL_SLOTS;

   logic [LB-1:0] limit_ff;

   logic [2:0]    func_ff;
   logic [SB-1:0] pidx_ff;
   logic [15:0]   bytes_ff;
   logic [CB-1:0] count_ff;
   logic [AB-1:0] base_ff;
   logic [AB-1:0] addr_ff;

   logic          busy_ff  [NS];
   logic [ZB-1:0] size_ff  [NS];
   logic [AB-1:0] start_ff [NS];
   logic [CB-1:0] total_ff [NS];
   logic [CB-1:0] free_ff  [NS];
   logic [CB-1:0] head_ff  [NS];
   logic [CB-1:0] fresh_ff [NS];

   logic [PB-1:0] prod_ff;
   logic [AB-1:0] off_ff;
   logic [ZB-1:0] rem_ff;
   logic [AB-1:0] quo_ff;
   logic [fbpa_pkg::STEP_BITS-1:0] step_ff;

   logic [1:0]    status_ff;
   logic [2:0]    assigned_ff;
   logic [31:0]   granted_ff;
   logic [16:0]   rbytes_ff;
   logic [8:0]    rtotal_ff;
   logic [8:0]    rfree_ff;

   logic [CB-1:0] link_rd_data;
   logic [LB-1:0] lim;
   logic          p_in_range;
   logic          ok;
   logic          found;
   logic [SB-1:0] free_slot;
   logic          create_go;
   logic [ZB-1:0] bytes_al;
   logic [AB-1:0] start_al;
   logic          head_valid;
   logic          fresh_avail;
   logic          alloc_go;
   logic [CB-1:0] idx_sel;
   logic [CB-1:0] mul_a;
   logic          rel_hit;
   logic          rel_push;
   logic          delete_go;
   logic [ZB:0]   trial;
   logic          trial_ge;
   logic [ZB-1:0] cur_size;
   logic [AB-1:0] cur_start;
   logic [CB-1:0] cur_total;
   logic [CB-1:0] cur_free;
   logic [CB-1:0] cur_head;
   logic [CB-1:0] cur_fresh;
   logic [1:0]    status_in;
   logic [2:0]    assigned_in;
   logic [31:0]   granted_in;
   logic [16:0]   rbytes_in;
   logic [8:0]    rtotal_in;
   logic [8:0]    rfree_in;

   assign cur_size  = size_ff[pidx_ff];
   assign cur_start = start_ff[pidx_ff];
   assign cur_total = total_ff[pidx_ff];
   assign cur_free  = free_ff[pidx_ff];
   assign cur_head  = head_ff[pidx_ff];
   assign cur_fresh = fresh_ff[pidx_ff];

   assign lim = (limit_ff > LB'(NS)) ? LB'(NS) : limit_ff;
   assign p_in_range = LB'(pidx_ff) < lim;
   assign ok = p_in_range && busy_ff[pidx_ff];

   always_comb begin
      found = 1'b0;
      free_slot = '0;
      for (int s = 0; s < NS; s++) begin
         if (!found && (LB'(s) < lim) && !busy_ff[s]) begin
            found = 1'b1;
            free_slot = SB'(s);
         end
      end
   end

   assign create_go = (func_ff == fbpa_pkg::FUNC_CREATE) && (bytes_ff != '0) &&
                      (count_ff != '0) && (count_ff <= CB'(fbpa_pkg::BLOCKS_PER_POOL)) && found;
   assign bytes_al  = (ZB'(bytes_ff) + ZB'(3)) & ~ZB'(3);
   assign start_al  = (base_ff + AB'(3)) & ~AB'(3);

   assign head_valid  = cur_head < CB'(fbpa_pkg::BLOCKS_PER_POOL);
   assign fresh_avail = cur_fresh < cur_total;
   assign alloc_go    = (func_ff == fbpa_pkg::FUNC_ALLOC) && ok && (head_valid || fresh_avail);
   assign idx_sel     = head_valid ? cur_head : cur_fresh;
   assign mul_a       = (func_ff == fbpa_pkg::FUNC_RELEASE) ? cur_total : idx_sel;

   assign rel_hit   = (func_ff == fbpa_pkg::FUNC_RELEASE) && ok && (cur_size != '0) &&
                      (off_ff < AB'(prod_ff));
   assign rel_push  = rel_hit && (rem_ff == '0);
   assign delete_go = (func_ff == fbpa_pkg::FUNC_DELETE) && ok;

   assign trial    = {rem_ff, quo_ff[AB-1]};
   assign trial_ge = trial >= {1'b0, cur_size};

   assign stat.alloc_link = (func_ff == fbpa_pkg::FUNC_ALLOC) && ok && head_valid;
   assign stat.release_ok = (func_ff == fbpa_pkg::FUNC_RELEASE) && ok;
   assign stat.rel_hit    = rel_hit;
   assign stat.div_last   = step_ff == fbpa_pkg::STEP_BITS'(fbpa_pkg::DIV_STEPS - 1);

   fbpa_ram #(
      .WIDTH (CB),
      .DEPTH (fbpa_pkg::LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.finish && rel_push),
      .wr_addr ({pidx_ff, quo_ff[IB-1:0]}),
      .wr_data (cur_head),
      .rd_en   (cmd.link_rd),
      .rd_addr ({pidx_ff, cur_head[IB-1:0]}),
      .rd_data (link_rd_data)
   );

   always_comb begin
      status_in   = fbpa_pkg::STATUS_FAIL;
      assigned_in = pidx_ff;
      granted_in  = '0;
      rbytes_in   = cur_size;
      rtotal_in   = cur_total;
      rfree_in    = cur_free;
      case (func_ff)
         fbpa_pkg::FUNC_CREATE: begin
            if (create_go) begin
               status_in   = fbpa_pkg::STATUS_OK;
               assigned_in = free_slot;
               rbytes_in   = bytes_al;
               rtotal_in   = count_ff;
               rfree_in    = count_ff;
            end
         end
         fbpa_pkg::FUNC_ALLOC: begin
            if (alloc_go) begin
               status_in  = fbpa_pkg::STATUS_OK;
               granted_in = 32'(cur_start + AB'(prod_ff));
               rfree_in   = cur_free - CB'(1);
            end
         end
         fbpa_pkg::FUNC_RELEASE: begin
            if (rel_push) begin
               status_in = fbpa_pkg::STATUS_OK;
               rfree_in  = cur_free + CB'(1);
            end else if (rel_hit) begin
               status_in = fbpa_pkg::STATUS_MISALIGNED;
            end
         end
         fbpa_pkg::FUNC_DELETE: begin
            if (delete_go) begin
               status_in = fbpa_pkg::STATUS_OK;
               rbytes_in = '0;
               rtotal_in = '0;
               rfree_in  = '0;
            end
         end
         fbpa_pkg::FUNC_QUERY: begin
            if (p_in_range) begin
               status_in = fbpa_pkg::STATUS_OK;
            end
         end
         default: begin
            status_in = fbpa_pkg::STATUS_FAIL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LB'(8);
      end else if (csr_valid) begin
         limit_ff <= csr_pools_in_use_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= req_func;
         pidx_ff  <= SB'(req_pool_index);
         bytes_ff <= req_requested_block_bytes;
         count_ff <= req_requested_block_count;
         base_ff  <= AB'(req_region_base);
         addr_ff  <= AB'(req_returned_block_address);
      end
      if (cmd.mul) begin
         prod_ff <= PB'(mul_a) * PB'(cur_size);
         off_ff  <= addr_ff - cur_start;
      end
      if (cmd.div_start) begin
         rem_ff  <= '0;
         quo_ff  <= off_ff;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= trial_ge ? ZB'(trial - {1'b0, cur_size}) : ZB'(trial);
         quo_ff  <= {quo_ff[AB-2:0], trial_ge};
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.finish) begin
         status_ff   <= status_in;
         assigned_ff <= assigned_in;
         granted_ff  <= granted_in;
         rbytes_ff   <= rbytes_in;
         rtotal_ff   <= rtotal_in;
         rfree_ff    <= rfree_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            busy_ff[s]  <= 1'b0;
            size_ff[s]  <= '0;
            start_ff[s] <= '0;
            total_ff[s] <= '0;
            free_ff[s]  <= '0;
            head_ff[s]  <= fbpa_pkg::LINK_NONE;
            fresh_ff[s] <= '0;
         end
      end else if (cmd.finish) begin
         if (create_go) begin
            busy_ff[free_slot]  <= 1'b1;
            size_ff[free_slot]  <= bytes_al;
            start_ff[free_slot] <= start_al;
            total_ff[free_slot] <= count_ff;
            free_ff[free_slot]  <= count_ff;
            head_ff[free_slot]  <= fbpa_pkg::LINK_NONE;
            fresh_ff[free_slot] <= '0;
         end
         if (alloc_go) begin
            free_ff[pidx_ff] <= cur_free - CB'(1);
            if (head_valid) begin
               head_ff[pidx_ff] <= link_rd_data;
            end else begin
               fresh_ff[pidx_ff] <= cur_fresh + CB'(1);
            end
         end
         if (rel_push) begin
            head_ff[pidx_ff] <= CB'(quo_ff[IB-1:0]);
            free_ff[pidx_ff] <= cur_free + CB'(1);
         end
         if (delete_go) begin
            busy_ff[pidx_ff]  <= 1'b0;
            size_ff[pidx_ff]  <= '0;
            start_ff[pidx_ff] <= '0;
            total_ff[pidx_ff] <= '0;
            free_ff[pidx_ff]  <= '0;
            head_ff[pidx_ff]  <= fbpa_pkg::LINK_NONE;
            fresh_ff[pidx_ff] <= '0;
         end
      end
   end

   assign rsp_status                = status_ff;
   assign rsp_assigned_pool         = assigned_ff;
   assign rsp_granted_block_address = granted_ff;
   assign rsp_pool_block_bytes      = rbytes_ff;
   assign rsp_pool_total_blocks     = rtotal_ff;
   assign rsp_pool_free_blocks      = rfree_ff;

endmodule

/* design/fbpa_ctrl.sv */
// Controller state machine that sequences one item through the datapath.
module fbpa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  fbpa_pkg::stat_type stat,
   output fbpa_pkg::cmd_type  cmd
);

   fbpa_pkg::state_type state_ff;
   fbpa_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == fbpa_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbpa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         fbpa_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = fbpa_pkg::S_DECODE;
            end
         end
         fbpa_pkg::S_DECODE: begin
            cmd.mul     = 1'b1;
            cmd.link_rd = stat.alloc_link;
            state_in    = stat.release_ok ? fbpa_pkg::S_CHECK : fbpa_pkg::S_FINISH;
         end
         fbpa_pkg::S_CHECK: begin
            if (stat.rel_hit) begin
               cmd.div_start = 1'b1;
               state_in      = fbpa_pkg::S_DIV;
            end else begin
               state_in = fbpa_pkg::S_FINISH;
            end
         end
         fbpa_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = fbpa_pkg::S_FINISH;
            end
         end
         fbpa_pkg::S_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = fbpa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fbpa_pkg::S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);
   end

`ifndef SYNTH
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == fbpa_pkg::S_DECODE)
      else $error("accepted item did not enter decode");
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item not presented");
   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbpa_pkg::S_DIV && !stat.div_last |=> state_ff == fbpa_pkg::S_DIV)
      else $error("divider left early");
   a_check_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbpa_pkg::S_CHECK && stat.rel_hit |=> state_ff == fbpa_pkg::S_DIV)
      else $error("release in range skipped the divider");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !cmd.finish)
      else $error("pending item overwritten");
`endif

endmodule

/* design/fixed_block_pool_allocator_top.sv */
// Top level of the fixed block pool allocator: controller plus datapath.
//
//   channel | direction | handshake              | content
//   req_    | in        | req_valid / req_ready  | one operation item
//   rsp_    | out       | rsp_valid / rsp_ready  | one result item per operation
//   csr_    | in        | csr_valid / csr_ready  | pools_in_use_limit write
//
// Create, allocate, delete, query, unknown codes and releases to an unusable pool pass through
// decode and finish; a release to a live pool whose offset misses it also passes through check.
// A release that falls inside its pool also runs the 32-step restoring divider between check
// and finish, which turns the address offset into a block index.
// Synchronous reset empties all pool slots and sets the limit to 8; the link memory is not
// cleared. One item is in flight at a time; a result waiting on rsp_ready stalls the next
// item only at its final step.
module fixed_block_pool_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_pools_in_use_limit,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [2:0]  req_pool_index,
   input  logic [15:0] req_requested_block_bytes,
   input  logic [8:0]  req_requested_block_count,
   input  logic [31:0] req_region_base,
   input  logic [31:0] req_returned_block_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_assigned_pool,
   output logic [31:0] rsp_granted_block_address,
   output logic [16:0] rsp_pool_block_bytes,
   output logic [8:0]  rsp_pool_total_blocks,
   output logic [8:0]  rsp_pool_free_blocks
);

   fbpa_pkg::cmd_type  cmd;
   fbpa_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbpa_datapath u_datapath (
      .clock                      (clock),
      .reset                      (reset),
      .csr_valid                  (csr_valid),
      .csr_pools_in_use_limit     (csr_pools_in_use_limit),
      .req_func                   (req_func),
      .req_pool_index             (req_pool_index),
      .req_requested_block_bytes  (req_requested_block_bytes),
      .req_requested_block_count  (req_requested_block_count),
      .req_region_base            (req_region_base),
      .req_returned_block_address (req_returned_block_address),
      .cmd                        (cmd),
      .stat                       (stat),
      .rsp_status                 (rsp_status),
      .rsp_assigned_pool          (rsp_assigned_pool),
      .rsp_granted_block_address  (rsp_granted_block_address),
      .rsp_pool_block_bytes       (rsp_pool_block_bytes),
      .rsp_pool_total_blocks      (rsp_pool_total_blocks),
      .rsp_pool_free_blocks       (rsp_pool_free_blocks)
   );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the fixed block pool allocator top level.
`timescale 1ns / 1ps

module tb;

   typedef struct {
      logic [2:0]  func;
      logic [2:0]  pool;
      logic [15:0] bytes;
      logic [8:0]  count;
      logic [31:0] base;
      logic [31:0] addr;
      bit          is_cfg;
      bit          drain;
      logic [3:0]  limit;
   } op_item_type;

   typedef struct {
      logic [1:0]  status;
      logic [2:0]  pool;
      logic [31:0] granted;
      logic [16:0] size;
      logic [8:0]  total;
      logic [8:0]  free;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_pools_in_use_limit = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [2:0]  req_pool_index = '0;
   logic [15:0] req_requested_block_bytes = '0;
   logic [8:0]  req_requested_block_count = '0;
   logic [31:0] req_region_base = '0;
   logic [31:0] req_returned_block_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_assigned_pool;
   logic [31:0] rsp_granted_block_address;
   logic [16:0] rsp_pool_block_bytes;
   logic [8:0]  rsp_pool_total_blocks;
   logic [8:0]  rsp_pool_free_blocks;

   fixed_block_pool_allocator_top u_dut (.*);

   always #2 clock = ~clock;

   // Predictor state.
   logic [3:0]  pm_limit;
   bit          pm_busy [fbpa_pkg::POOL_SLOTS];
   logic [16:0] pm_size [fbpa_pkg::POOL_SLOTS];
   logic [31:0] pm_start [fbpa_pkg::POOL_SLOTS];
   logic [8:0]  pm_total [fbpa_pkg::POOL_SLOTS];
   logic [8:0]  pm_free [fbpa_pkg::POOL_SLOTS];
   logic [8:0]  pm_head [fbpa_pkg::POOL_SLOTS];
   logic [8:0]  pm_fresh [fbpa_pkg::POOL_SLOTS];
   logic [8:0]  pm_link [fbpa_pkg::POOL_SLOTS][fbpa_pkg::BLOCKS_PER_POOL];

   op_item_type pending_ops[$];
   result_type  expected_results[$];
   int          fail_count = 0;
   int          result_count = 0;
   int          req_count = 0;
   int          cfg_count = 0;
   int          status_seen [3];
   int          func_seen [8];

   function automatic void clear_pool(int p);
      pm_busy[p] = 0;
      pm_size[p] = '0;
      pm_start[p] = '0;
      pm_total[p] = '0;
      pm_free[p] = '0;
      pm_head[p] = fbpa_pkg::LINK_NONE;
      pm_fresh[p] = '0;
   endfunction

   function automatic result_type predict_result(op_item_type it);
      result_type r;
      int lim;
      int p;
      int idx;
      bit ok;
      logic [63:0] span;
      logic [31:0] off;
      lim = (pm_limit < fbpa_pkg::POOL_SLOTS) ? pm_limit : fbpa_pkg::POOL_SLOTS;
      p = it.pool;
      ok = (p < lim) && pm_busy[p];
      r.status = fbpa_pkg::STATUS_FAIL;
      r.pool = it.pool;
      r.granted = '0;
      case (it.func)
         fbpa_pkg::FUNC_CREATE: begin
            if (it.bytes != 0 && it.count != 0 && it.count <= fbpa_pkg::BLOCKS_PER_POOL) begin
               for (int s = 0; s < lim; s++) begin
                  if (!pm_busy[s]) begin
                     clear_pool(s);
                     pm_busy[s] = 1;
                     pm_size[s] = (17'(it.bytes) + 17'd3) & ~17'd3;
                     pm_start[s] = (it.base + 32'd3) & ~32'd3;
                     pm_total[s] = it.count;
                     pm_free[s] = it.count;
                     r.status = fbpa_pkg::STATUS_OK;
                     r.pool = 3'(s);
                     p = s;
                     break;
                  end
               end
            end
         end
         fbpa_pkg::FUNC_ALLOC: begin
            if (ok) begin
               idx = -1;
               if (pm_head[p] < fbpa_pkg::BLOCKS_PER_POOL) begin
                  idx = pm_head[p];
                  pm_head[p] = pm_link[p][idx];
               end else if (pm_fresh[p] < pm_total[p]) begin
                  idx = pm_fresh[p];
                  pm_fresh[p] = pm_fresh[p] + 9'd1;
               end
               if (idx >= 0) begin
                  r.granted = pm_start[p] + 32'(idx) * 32'(pm_size[p]);
                  pm_free[p] = pm_free[p] - 9'd1;
                  r.status = fbpa_pkg::STATUS_OK;
               end
            end
         end
         fbpa_pkg::FUNC_RELEASE: begin
            if (ok) begin
               span = 64'(pm_size[p]) * 64'(pm_total[p]);
               off = it.addr - pm_start[p];
               if (pm_size[p] != 0 && 64'(off) < span) begin
                  if (off % 32'(pm_size[p]) != 0) begin
                     r.status = fbpa_pkg::STATUS_MISALIGNED;
                  end else begin
                     idx = off / 32'(pm_size[p]);
                     if (idx < fbpa_pkg::BLOCKS_PER_POOL) begin
                        pm_link[p][idx] = pm_head[p];
                        pm_head[p] = 9'(idx);
                        pm_free[p] = pm_free[p] + 9'd1;
                        r.status = fbpa_pkg::STATUS_OK;
                     end
                  end
               end
            end
         end
         fbpa_pkg::FUNC_DELETE: begin
            if (ok) begin
               clear_pool(p);
               r.status = fbpa_pkg::STATUS_OK;
            end
         end
         fbpa_pkg::FUNC_QUERY: begin
            if (p < lim) r.status = fbpa_pkg::STATUS_OK;
         end
         default: ;
      endcase
      r.size = pm_size[p];
      r.total = pm_total[p];
      r.free = pm_free[p];
      return r;
   endfunction

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic op_item_type blank_op();
      op_item_type it;
      it.func = fbpa_pkg::FUNC_QUERY;
      it.pool = '0;
      it.bytes = '0;
      it.count = '0;
      it.base = '0;
      it.addr = '0;
      it.is_cfg = 0;
      it.drain = 0;
      it.limit = '0;
      return it;
   endfunction

   function automatic void push_op(logic [2:0] f, logic [2:0] p, logic [15:0] b,
                                   logic [8:0] c, logic [31:0] base, logic [31:0] a);
      op_item_type it;
      it = blank_op();
      it.func = f;
      it.pool = p;
      it.bytes = b;
      it.count = c;
      it.base = base;
      it.addr = a;
      pending_ops.push_back(it);
   endfunction

   function automatic void push_cfg(logic [3:0] v);
      op_item_type it;
      it = blank_op();
      it.is_cfg = 1;
      it.limit = v;
      pending_ops.push_back(it);
   endfunction

   function automatic void push_drain();
      op_item_type it;
      it = blank_op();
      it.drain = 1;
      pending_ops.push_back(it);
   endfunction

   // Shadow of the pools as the stimulus sees them, to aim releases at real blocks.
   logic [31:0] gen_start [8];
   logic [16:0] gen_size [8];
   int          gen_total [8];
   logic [31:0] gen_out [8][$];

   function automatic void gen_random_op();
      int k;
      int p;
      int n;
      logic [31:0] a;
      logic [15:0] b;
      k = $urandom_range(0, 99);
      p = $urandom_range(0, 7);
      if (k < 12) begin
         b = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 12);
         a = $urandom;
         push_op(fbpa_pkg::FUNC_CREATE, 3'(p), b, 9'(n), a, $urandom);
      end else if (k < 45) begin
         push_op(fbpa_pkg::FUNC_ALLOC, 3'(p), 16'($urandom), 9'($urandom), $urandom, $urandom);
      end else if (k < 78) begin
         if (gen_out[p].size() > 0 && $urandom_range(0, 3) != 0) begin
            n = $urandom_range(0, gen_out[p].size() - 1);
            a = gen_out[p][n];
            gen_out[p].delete(n);
         end else if ($urandom_range(0, 1) == 0 && gen_size[p] != 0) begin
            a = gen_start[p] + 32'($urandom_range(0, gen_total[p] + 1)) * 32'(gen_size[p])
                + 32'($urandom_range(0, 2));
         end else begin
            a = $urandom;
         end
         push_op(fbpa_pkg::FUNC_RELEASE, 3'(p), 16'($urandom), 9'($urandom), $urandom, a);
      end else if (k < 84) begin
         push_op(fbpa_pkg::FUNC_DELETE, 3'(p), 16'($urandom), 9'($urandom), $urandom, $urandom);
         gen_out[p].delete();
      end else if (k < 96) begin
         push_op(fbpa_pkg::FUNC_QUERY, 3'(p), 16'($urandom), 9'($urandom), $urandom, $urandom);
      end else begin
         push_op(3'($urandom_range(5, 7)), 3'(p), 16'($urandom), 9'($urandom),
                 $urandom, $urandom);
      end
   endfunction

   // Driver: request and register channels, fed from one ordered queue.
   int  req_gap = 0;
   bit  stim_done = 0;
   bit  req_fired = 0;
   bit  csr_fired = 0;

   always @(posedge clock) begin
      op_item_type it;
      if (!reset) begin
         if (req_valid && req_ready) begin
            it = blank_op();
            it.func = req_func;
            it.pool = req_pool_index;
            it.bytes = req_requested_block_bytes;
            it.count = req_requested_block_count;
            it.base = req_region_base;
            it.addr = req_returned_block_address;
            func_seen[req_func]++;
            req_count++;
            expected_results.push_back(predict_result(it));
            req_gap = pick_gap();
            req_fired = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            pm_limit = csr_pools_in_use_limit;
            cfg_count++;
            csr_fired = 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      op_item_type it;
      bit          next_req;
      bit          next_csr;
      if (!reset) begin
         next_req = req_valid && !req_fired;
         next_csr = csr_valid && !csr_fired;
         req_fired = 1'b0;
         csr_fired = 1'b0;
         if (!next_req && !next_csr) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_ops.size() == 0) begin
               stim_done = 1'b1;
            end else if (!((pending_ops[0].is_cfg || pending_ops[0].drain)
                           && expected_results.size() != 0)) begin
               it = pending_ops.pop_front();
               if (it.is_cfg) begin
                  csr_pools_in_use_limit <= it.limit;
                  next_csr = 1'b1;
               end else if (!it.drain) begin
                  req_func <= it.func;
                  req_pool_index <= it.pool;
                  req_requested_block_bytes <= it.bytes;
                  req_requested_block_count <= it.count;
                  req_region_base <= it.base;
                  req_returned_block_address <= it.addr;
                  next_req = 1'b1;
               end
            end
         end
         req_valid <= next_req;
         csr_valid <= next_csr;
      end
   end

   // Monitor and receiver stalls.
   int rsp_gap = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_gap = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            $error("unexpected result item: status %0d pool %0d", rsp_status,
                   rsp_assigned_pool);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_status <= 2) status_seen[rsp_status]++;
            if (rsp_status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_status);
               fail_count++;
            end
            if (rsp_assigned_pool !== e.pool) begin
               $error("assigned_pool: expected %0d actual %0d", e.pool, rsp_assigned_pool);
               fail_count++;
            end
            if (rsp_granted_block_address !== e.granted) begin
               $error("granted_block_address: expected %h actual %h", e.granted,
                      rsp_granted_block_address);
               fail_count++;
            end
            if (rsp_pool_block_bytes !== e.size) begin
               $error("pool_block_bytes: expected %0d actual %0d", e.size,
                      rsp_pool_block_bytes);
               fail_count++;
            end
            if (rsp_pool_total_blocks !== e.total) begin
               $error("pool_total_blocks: expected %0d actual %0d", e.total,
                      rsp_pool_total_blocks);
               fail_count++;
            end
            if (rsp_pool_free_blocks !== e.free) begin
               $error("pool_free_blocks: expected %0d actual %0d", e.free,
                      rsp_pool_free_blocks);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int limits [6];
      pm_limit = 4'd8;
      for (int p = 0; p < fbpa_pkg::POOL_SLOTS; p++) begin
         clear_pool(p);
         for (int i = 0; i < fbpa_pkg::BLOCKS_PER_POOL; i++) pm_link[p][i] = '0;
      end
      for (int p = 0; p < 8; p++) begin
         gen_start[p] = '0;
         gen_size[p] = '0;
         gen_total[p] = 0;
      end

      // Directed part: bad creates, extremes of the fields, wrap of addresses.
      push_op(fbpa_pkg::FUNC_CREATE, 3'd0, 16'd0, 9'd4, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_CREATE, 3'd0, 16'd8, 9'd0, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_CREATE, 3'd0, 16'd8, 9'd257, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_ALLOC, 3'd3, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_CREATE, 3'd7, 16'd5, 9'd3, 32'hFFFF_FFF9, 32'h0);
      push_op(fbpa_pkg::FUNC_CREATE, 3'd2, 16'hFFFF, 9'd256, 32'h1000_0001, 32'hFFFF_FFFF);
      push_op(fbpa_pkg::FUNC_ALLOC, 3'd0, 16'hFFFF, 9'h1FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_op(fbpa_pkg::FUNC_ALLOC, 3'd0, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_ALLOC, 3'd0, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_ALLOC, 3'd0, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_RELEASE, 3'd0, 16'd0, 9'd0, 32'h0, 32'h0000_0004);
      push_op(fbpa_pkg::FUNC_RELEASE, 3'd0, 16'd0, 9'd0, 32'h0, 32'h0000_0005);
      push_op(fbpa_pkg::FUNC_RELEASE, 3'd0, 16'd0, 9'd0, 32'h0, 32'h0000_000C);
      push_op(fbpa_pkg::FUNC_RELEASE, 3'd0, 16'd0, 9'd0, 32'h0, 32'hFFFF_FFFC);
      push_op(fbpa_pkg::FUNC_RELEASE, 3'd0, 16'd0, 9'd0, 32'h0, 32'hFFFF_FFFC);
      push_op(fbpa_pkg::FUNC_ALLOC, 3'd0, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_RELEASE, 3'd1, 16'd0, 9'd0, 32'h0, 32'h0000_0000);
      push_op(fbpa_pkg::FUNC_ALLOC, 3'd1, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_RELEASE, 3'd1, 16'd0, 9'd0, 32'h0, 32'h1000_0004);
      push_op(fbpa_pkg::FUNC_QUERY, 3'd1, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_DELETE, 3'd0, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_DELETE, 3'd0, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(fbpa_pkg::FUNC_QUERY, 3'd7, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(3'd7, 3'd5, 16'd0, 9'd0, 32'h0, 32'h0);
      push_op(3'd5, 3'd2, 16'd0, 9'd0, 32'h0, 32'h0);
      push_drain();

      // Random phases under several limits, extremes included.
      limits = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd6};
      for (int ph = 0; ph < 6; ph++) begin
         push_cfg(4'(limits[ph]));
         for (int i = 0; i < 105; i++) begin
            gen_random_op();
            if (ph == 3 && i == 50) push_drain();
         end
      end
      push_cfg(4'd8);
      push_op(fbpa_pkg::FUNC_QUERY, 3'd0, 16'd0, 9'd0, 32'h0, 32'h0);
   end

   // Rough tracking of allocated addresses, so that many releases hit real blocks.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_status == fbpa_pkg::STATUS_OK) begin
         if (rsp_pool_block_bytes == 0) begin
            gen_size[rsp_assigned_pool] = '0;
            gen_total[rsp_assigned_pool] = 0;
         end else begin
            gen_start[rsp_assigned_pool] = pm_start[rsp_assigned_pool];
            gen_size[rsp_assigned_pool] = rsp_pool_block_bytes;
            gen_total[rsp_assigned_pool] = rsp_pool_total_blocks;
            if (rsp_granted_block_address != 0)
               gen_out[rsp_assigned_pool].push_back(rsp_granted_block_address);
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && expected_results.size() == 0);
      repeat (60) @(posedge clock);
      $display("Covered %0d operations and %0d register writes; %0d results checked.",
               req_count, cfg_count, result_count);
      $display("Status seen: ok %0d, fail %0d, misaligned %0d.", status_seen[0],
               status_seen[1], status_seen[2]);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
